// ===== rtl/core/chr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types, constants and helpers of the stereo chorus.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int SAMPLE_W        = 24;
  localparam int PHASE_W         = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int SINE_SIZE_DEF   = 1024;
  localparam int PROD_W          = 42;
  localparam int MIX_W           = 44;
  localparam int SAT_W           = 48;
  localparam int STEP_W          = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd5;

  localparam logic [20:0] PHASE_STEP_RST = 21'd44739;
  localparam logic [31:0] RIGHT_OFS_RST  = 32'd1073741824;
  localparam logic [18:0] BASE_DELAY_RST = 19'd184320;
  localparam logic [18:0] MOD_DEPTH_RST  = 19'd36864;
  localparam logic [15:0] FEEDBACK_RST   = 16'd13107;
  localparam logic [16:0] WET_MIX_RST    = 17'd19661;

  localparam logic [15:0] FB_MAX  = 16'd62259;
  localparam logic [16:0] WET_ONE = 17'd65536;

  // lane sequence steps
  localparam logic [STEP_W-1:0] STEP_X2  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_P1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_P2  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_P3  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DEP = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADR = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RD1 = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RD2 = 4'd7;
  localparam logic [STEP_W-1:0] STEP_INT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MIX = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUT = 4'd10;

  typedef struct packed {
    logic              start;
    logic              busy;
    logic [STEP_W-1:0] step;
    logic              commit;
  } chr_ctrl_t;

  typedef struct packed {
    logic [18:0] base_delay;
    logic [18:0] mod_depth;
    logic [15:0] feedback_gain;
    logic [16:0] wet_mix;
  } chr_cfg_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/chr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chr_if
// Valid/ready channels of the stereo chorus: sample in, sample out, config.
// ----------------------------------------------------------------------------
interface chr_in_if import chr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface chr_out_if import chr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface chr_cfg_if import chr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/chr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module chr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/chr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chr_lane
// One chorus channel: sine lfo, modulated delay read with interpolation,
// feedback write back and dry/wet mix, one step per cycle, holding in the output step while the output stalls.
// ----------------------------------------------------------------------------
module chr_lane import chr_pkg::*; #(
  parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire chr_ctrl_t                        ctrl_i,
  input  wire chr_cfg_t                         cfg_i,
  input  wire logic        [PHASE_W-1:0]        phase_i,
  input  wire logic signed [SAMPLE_W-1:0]       sample_i,
  input  wire logic        [$clog2(DELAY_DEPTH)-1:0] wp_i,
  input  wire logic                             wrapped_i,
  output logic signed      [SAMPLE_W-1:0]       sample_o
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int LW    = $clog2(SINE_TABLE_SIZE);
  localparam int XSH   = 18 - LW;
  localparam int DW    = ((AW + 9 > 21) ? AW + 9 : 21) + 1;
  localparam int DMAX  = (DELAY_DEPTH - 2) * 256;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic [16:0]                x_q;
  logic [1:0]                 quad_q;
  logic [16:0]                x2_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [MIX_W-1:0]    mix_q, mix_d;
  logic [AW-1:0]              i1_q;
  logic [7:0]                 frac_q;
  logic signed [SAMPLE_W-1:0] s1_q;
  logic                       rvalid_q;

  logic [AW-1:0]              raddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] rsample;
  logic [SAMPLE_W-1:0]        wdata;

  logic [LW-3:0]              low;
  logic [15:0]                xr;
  logic [16:0]                x_d;
  logic [17:0]                p;
  logic [16:0]                pc;
  logic signed [17:0]         lfo;
  logic signed [DW-1:0]       dly;
  logic [AW+7:0]              dc;
  logic [AW+7:0]              pos;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W+1:0] dl_w;
  logic signed [SAMPLE_W-1:0] delayed;
  logic [15:0]                fb;
  logic [16:0]                wet;
  logic [16:0]                dry;

  always_comb begin
    low = phase_i[PHASE_W-3 -: LW-2];
    xr  = 16'(low) << XSH;
    x_d = phase_i[PHASE_W-2] ? (17'd65536 - {1'b0, xr}) : {1'b0, xr};
  end

  assign rsample = rvalid_q ? $signed(rdata) : '0;
  assign fb      = (cfg_i.feedback_gain > FB_MAX) ? FB_MAX : cfg_i.feedback_gain;
  assign wet     = (cfg_i.wet_mix > WET_ONE) ? WET_ONE : cfg_i.wet_mix;
  assign dry     = WET_ONE - wet;

  always_comb begin
    prod_d  = prod_q;
    mix_d   = mix_q;
    p       = prod_q[33:16];
    pc      = (p > 18'd65536) ? 17'd65536 : p[16:0];
    lfo     = quad_q[1] ? -$signed({1'b0, pc}) : $signed({1'b0, pc});
    dly     = $signed(DW'(cfg_i.base_delay)) + DW'(prod_q >>> 16);
    if (dly < $signed(DW'(256))) begin
      dc = (AW+8)'(256);
    end else if (dly > $signed(DW'(DMAX))) begin
      dc = (AW+8)'(DMAX);
    end else begin
      dc = dly[AW+7:0];
    end
    pos     = {wp_i, 8'b0} - dc;
    diff    = (SAMPLE_W+1)'(rsample) - (SAMPLE_W+1)'(s1_q);
    dl_w    = (SAMPLE_W+2)'(s1_q) + (SAMPLE_W+2)'(prod_q >>> 8);
    delayed = dl_w[SAMPLE_W-1:0];
    case (ctrl_i.step)
      STEP_X2: begin
        prod_d = PROD_W'($signed({1'b0, x_q})) * PROD_W'($signed({1'b0, x_q}));
      end
      STEP_P1: begin
        prod_d = PROD_W'($signed({1'b0, prod_q[32:16]})) * PROD_W'(4640);
      end
      STEP_P2: begin
        prod_d = PROD_W'($signed({1'b0, 17'd42048 - {4'b0, prod_q[28:16]}}))
               * PROD_W'($signed({1'b0, x2_q}));
      end
      STEP_P3: begin
        prod_d = PROD_W'($signed({1'b0, 17'd102944 - {1'b0, prod_q[31:16]}}))
               * PROD_W'($signed({1'b0, x_q}));
      end
      STEP_DEP: begin
        prod_d = PROD_W'(lfo) * PROD_W'($signed({1'b0, cfg_i.mod_depth}));
      end
      STEP_INT: begin
        prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, frac_q}));
      end
      STEP_MIX: begin
        prod_d = PROD_W'(delayed) * PROD_W'($signed({1'b0, fb}));
        mix_d  = MIX_W'(sample_q) * MIX_W'($signed({1'b0, dry}))
               + MIX_W'(delayed) * MIX_W'($signed({1'b0, wet}));
      end
      default: begin
        prod_d = prod_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      sample_q <= sample_i;
      x_q      <= x_d;
      quad_q   <= phase_i[PHASE_W-1 -: 2];
    end
    if (ctrl_i.busy) begin
      prod_q <= prod_d;
      mix_q  <= mix_d;
      if (ctrl_i.step == STEP_P1) begin
        x2_q <= prod_q[32:16];
      end
      if (ctrl_i.step == STEP_ADR) begin
        i1_q   <= pos[AW+7:8];
        frac_q <= pos[7:0];
      end
      if (ctrl_i.step == STEP_RD2) begin
        s1_q <= rsample;
      end
    end
  end

  // entries not yet written since reset read as zero
  assign raddr = (ctrl_i.step == STEP_RD2) ? i1_q + AW'(1) : i1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= wrapped_i || (raddr < wp_i);
    end
  end

  assign wdata    = sat_sample(SAT_W'(sample_q) + SAT_W'(prod_q >>> 16));
  assign sample_o = sat_sample(SAT_W'(mix_q >>> 16));

  chr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.commit),
    .waddr_i (wp_i),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // the interpolated sample always lies between its two neighbors
  a_delayed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.busy && ctrl_i.step == STEP_MIX) |->
      ((delayed >= s1_q && delayed <= rsample) || (delayed <= s1_q && delayed >= rsample)
       || (delayed >= s1_q && delayed <= $past(rsample))
       || (delayed <= s1_q && delayed >= $past(rsample))))
    else $error("interpolated sample out of range");

  a_lfo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.busy && ctrl_i.step == STEP_DEP) |-> (lfo <= 18'sd65536 && lfo >= -18'sd65536))
    else $error("lfo value out of range");

endmodule
`default_nettype wire

// ===== rtl/core/stereo_chorus.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_chorus
// Stereo chorus with sine modulated delay lines, feedback and dry/wet mix.
// ----------------------------------------------------------------------------
// usage:
//   in_i   : one left/right sample pair per transfer
//   out_o  : one chorused pair per input pair, in order
//   cfg_i  : register writes (index, data), always ready, write only while idle
// the two channels run side by side in their own lanes, each owning its delay
// memory; a pair walks through eleven steps (four sine products, depth
// product, address, two memory reads, interpolation, mix, output) and reaches
// the result register when its output step commits; in_i is ready again from
// that edge on, so a pair is taken only once the last has committed. reset
// clears the lfo phase, write position and step control and loads the config
// registers with defaults; the delay memories are not swept, entries not written
// since reset read as zero. when out_o stalls with a result held, the next
// pair is taken and waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module stereo_chorus import chr_pkg::*; #(
  parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chr_in_if.sink    in_i,
  chr_out_if.source out_o,
  chr_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(DELAY_DEPTH);

  logic [20:0]        phase_step_q;
  logic [31:0]        right_ofs_q;
  chr_cfg_t           cfg_q;
  logic               busy_q;
  logic [STEP_W-1:0]  step_q;
  logic [AW-1:0]      wp_q;
  logic               wrapped_q;
  logic [PHASE_W-1:0] phase_q;
  logic               out_valid_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;

  logic               accept;
  logic               commit;
  chr_ctrl_t          ctrl;
  logic signed [SAMPLE_W-1:0] left_res, right_res;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !busy_q;
  assign accept      = in_i.valid && !busy_q;
  assign commit      = busy_q && (step_q == STEP_OUT) && (!out_valid_q || out_o.ready);

  assign ctrl.start  = accept;
  assign ctrl.busy   = busy_q;
  assign ctrl.step   = step_q;
  assign ctrl.commit = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q        <= PHASE_STEP_RST;
      right_ofs_q         <= RIGHT_OFS_RST;
      cfg_q.base_delay    <= BASE_DELAY_RST;
      cfg_q.mod_depth     <= MOD_DEPTH_RST;
      cfg_q.feedback_gain <= FEEDBACK_RST;
      cfg_q.wet_mix       <= WET_MIX_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PHASE_STEP: phase_step_q        <= cfg_i.data[20:0];
        REG_RIGHT_OFS:  right_ofs_q         <= cfg_i.data[31:0];
        REG_BASE_DELAY: cfg_q.base_delay    <= cfg_i.data[18:0];
        REG_MOD_DEPTH:  cfg_q.mod_depth     <= cfg_i.data[18:0];
        REG_FEEDBACK:   cfg_q.feedback_gain <= cfg_i.data[15:0];
        REG_WET_MIX:    cfg_q.wet_mix       <= cfg_i.data[16:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_X2;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= STEP_X2;
      end else if (commit) begin
        busy_q <= 1'b0;
      end else if (busy_q && step_q != STEP_OUT) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (commit) begin
        wp_q    <= wp_q + AW'(1);
        phase_q <= phase_q + PHASE_W'(phase_step_q);
        if (wp_q == AW'(DELAY_DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge both lanes into the output register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      left_q  <= left_res;
      right_q <= right_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = left_q;
  assign out_o.right_out = right_q;

  chr_lane #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_lane_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .phase_i   (phase_q),
    .sample_i  (in_i.left_in),
    .wp_i      (wp_q),
    .wrapped_i (wrapped_q),
    .sample_o  (left_res)
  );

  chr_lane #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_lane_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .phase_i   (phase_q + right_ofs_q),
    .sample_i  (in_i.right_in),
    .wp_i      (wp_q),
    .wrapped_i (wrapped_q),
    .sample_o  (right_res)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && step_q == STEP_X2))
    else $error("accepted pair did not start the sequence");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= STEP_OUT))
    else $error("step counter past last step");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_valid_q && !busy_q))
    else $error("commit did not register a result");

  a_wrap_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wrapped_q) |-> (wp_q == '0))
    else $error("wrap flag set away from position zero");

endmodule
`default_nettype wire
